[rtl/fbs8_pkg.sv]
package fbs8_pkg;

    // Largest number of bytes one item can produce: five header bytes,
    // one payload byte and the checksum byte.
    localparam int MaxResults = 7;
    localparam int HeaderLen  = 5;
    localparam int SlotBits   = $clog2(MaxResults + 1);

    localparam logic [7:0] HeaderOneReset = 8'd170;
    localparam logic [7:0] HeaderTwoReset = 8'd85;

    // Register select taken from the byte address (address bit 2).
    localparam logic RegHeaderOne = 1'b0;
    localparam logic RegHeaderTwo = 1'b1;

    typedef logic [SlotBits-1:0] slot_cnt_t;

    typedef struct packed {
        logic [7:0]  frame_type;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic        is_first;
        logic        is_last;
        logic        carries_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_frame;
    } out_item_t;

    // Byte offered by the expander to the output register.
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } head_t;

endpackage

[rtl/fbs8_expand.sv]
module fbs8_expand
    import fbs8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  in_item_t   item,
    input  logic [7:0] header_one,
    input  logic [7:0] header_two,
    input  logic       take,
    output head_t      head
);

    out_item_t slots_reg [MaxResults];
    out_item_t slots_next [MaxResults];
    slot_cnt_t rem_reg;
    slot_cnt_t rem_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;

    logic       accept;
    logic [7:0] seed;
    logic [7:0] total;
    slot_cnt_t  data_pos;
    slot_cnt_t  sum_pos;
    slot_cnt_t  new_count;
    out_item_t  new_slots [MaxResults];

    // A new item may enter once the current one has nothing left, or its
    // last byte moves to the output register in this cycle.
    assign item_stall = !((rem_reg == '0) || ((rem_reg == slot_cnt_t'(1)) && take));
    assign accept     = item_valid && !item_stall;

    assign head.valid = (rem_reg != '0);
    assign head.item  = slots_reg[0];

    // Checksum path: seed from the frame type and length bytes on a frame
    // start, then add the payload byte. All sums wrap at eight bits.
    assign seed  = item.is_first
                 ? 8'(item.frame_type + item.payload_length[7:0]
                      + item.payload_length[15:8])
                 : sum_reg;
    assign total = item.carries_byte ? 8'(seed + item.payload_byte) : seed;

    assign data_pos  = item.is_first ? slot_cnt_t'(HeaderLen) : '0;
    assign sum_pos   = data_pos + slot_cnt_t'(item.carries_byte);
    assign new_count = sum_pos + slot_cnt_t'(item.is_last);

    always_comb
    begin
        for (int i = 0; i < MaxResults; i++)
        begin
            new_slots[i] = '0;
        end
        if (item.is_first)
        begin
            new_slots[0] = '{out_byte: header_one, end_of_frame: 1'b0};
            new_slots[1] = '{out_byte: header_two, end_of_frame: 1'b0};
            new_slots[2] = '{out_byte: item.frame_type, end_of_frame: 1'b0};
            new_slots[3] = '{out_byte: item.payload_length[7:0], end_of_frame: 1'b0};
            new_slots[4] = '{out_byte: item.payload_length[15:8], end_of_frame: 1'b0};
        end
        if (item.carries_byte)
        begin
            new_slots[data_pos] = '{out_byte: item.payload_byte, end_of_frame: 1'b0};
        end
        if (item.is_last)
        begin
            new_slots[sum_pos] = '{out_byte: total, end_of_frame: 1'b1};
        end
    end

    always_comb
    begin
        slots_next = slots_reg;
        rem_next   = rem_reg;
        sum_next   = sum_reg;
        if (accept)
        begin
            slots_next = new_slots;
            rem_next   = new_count;
            sum_next   = item.is_last ? 8'h00 : total;
        end
        else if (take && (rem_reg != '0))
        begin
            for (int i = 0; i < MaxResults - 1; i++)
            begin
                slots_next[i] = slots_reg[i + 1];
            end
            slots_next[MaxResults - 1] = '0;
            rem_next = rem_reg - slot_cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slots_reg <= slots_next;
    end

    // The pending byte count never goes past the longest expansion.
    assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= slot_cnt_t'(MaxResults))
        else $error("pending byte count out of range");

    // Closing a frame leaves a clean sum for the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.is_last) |=> (sum_reg == 8'h00))
        else $error("sum not cleared after checksum");

    // A byte handed on without a new item shortens the queue by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && (rem_reg != '0) && !accept) |=> (rem_reg == $past(rem_reg) - slot_cnt_t'(1)))
        else $error("pending byte count did not step down");

    // Without a new item the running sum holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(sum_reg))
        else $error("sum changed without an item");

endmodule

[rtl/frame_builder_sum8_unit.sv]
// Channel | Signals                                | Direction | Payload
// --------+----------------------------------------+-----------+-----------------
// item    | item_valid, item_stall, item           | in        | in_item_t
// frame   | frame_valid, frame_stall, frame_byte   | out       | out_item_t
// config  | psel, penable, pwrite, paddr, pwdata,  | in / out  | two 8-bit
//         | prdata, pready                         |           | header registers
//
// Each item produces its bytes one after another: one byte for a
// payload-only item, up to seven for an item that opens and closes a frame.
// The single output register moves one byte per cycle while the frame side
// does not stall. An item that produces no byte is taken and leaves no trace.
// Reset (rst_n low, asynchronous) empties the pipeline, clears the running
// sum and restores the header registers to 0xAA and 0x55.
// A stall on the frame side holds the output byte; the item side then stalls
// once the bytes of the current item are all waiting.
module frame_builder_sum8_unit
    import fbs8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  in_item_t    item,

    output logic        frame_valid,
    input  logic        frame_stall,
    output out_item_t   frame_byte,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] header_one_reg;
    logic [7:0] header_two_reg;
    logic       cfg_write;

    logic       frame_valid_reg;
    out_item_t  frame_byte_reg;
    logic       take;
    head_t      head;

    // Configuration port. The block never inserts wait states: pready is tied high.
    // The register is chosen by address bit 2; the low byte bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            RegHeaderOne: prdata = {24'd0, header_one_reg};
            RegHeaderTwo: prdata = {24'd0, header_two_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_one_reg <= HeaderOneReset;
            header_two_reg <= HeaderTwoReset;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                RegHeaderOne: header_one_reg <= pwdata[7:0];
                RegHeaderTwo: header_two_reg <= pwdata[7:0];
                default:      header_one_reg <= header_one_reg;
            endcase
        end
    end

    // The output register can take a new byte when it is empty or when its
    // current byte leaves in this cycle.
    assign take = !frame_valid_reg || !frame_stall;

    fbs8_expand u_expand
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .header_one (header_one_reg),
        .header_two (header_two_reg),
        .take       (take),
        .head       (head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            frame_valid_reg <= head.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && head.valid)
        begin
            frame_byte_reg <= head.item;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame_byte  = frame_byte_reg;

endmodule
